### src/lci_pkg.sv
// Shared types, constants and elaboration-time helpers for the LSTM layer unit.
package lci_pkg;

  localparam int OP_WEIGHT  = 0;
  localparam int OP_FEATURE = 1;

  localparam int               ONE_Q = 2048;
  localparam longint unsigned  ONE_E = 64'd1073741824;

  // Control for one gate-sum cell of the ring.
  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctrl_t;

  // Saturate a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Restoring division; used only while the activation tables are built.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      q = q << 1;
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-a) in Q.30 for a in Q.30; used only to build the activation tables.
  function automatic longint unsigned exp_neg(input longint unsigned a);
    longint unsigned b;
    longint unsigned term;
    longint unsigned e;
    longint          sum;
    b    = a >> 5;
    term = ONE_E;
    sum  = longint'(ONE_E);
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * b) >> 30, 64'(k));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    e = (sum > 0) ? longint'(sum) : 64'd0;
    for (int k = 0; k < 5; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    if (e > ONE_E) begin
      e = ONE_E;
    end
    return e;
  endfunction

endpackage

### src/lci_ram.sv
// Generic simple dual-port RAM with registered read data.
module lci_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 608
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/lci_gate_cell.sv
// One cell of the gate-sum ring: holds a 32-bit sum and passes it to its neighbor.
module lci_gate_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lci_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0] d,
  output logic signed [31:0] q
);

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= d;
    end
  end

endmodule

### src/lci_act_lut.sv
// Sigmoid and tanh lookup with input clamping; two register stages.
module lci_act_lut #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic signed [15:0] x,
  input  logic               tanh_sel,
  output logic signed [15:0] val_r
);

  localparam int IDX_W = $clog2(DEPTH);

  logic signed [15:0] sig_tab  [DEPTH];
  logic signed [15:0] tanh_tab [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_tab
    localparam longint          S  = 2 * i + 1 - DEPTH;
    localparam longint unsigned N  = (S < 0) ? longint'(-S) : longint'(S);
    localparam longint unsigned ES = lci_pkg::exp_neg((N << 33) / DEPTH);
    localparam longint unsigned ET = lci_pkg::exp_neg((N << 34) / DEPTH);
    localparam longint unsigned DS = lci_pkg::ONE_E + ES;
    localparam longint unsigned DT = lci_pkg::ONE_E + ET;
    localparam longint SP = longint'(((longint'(lci_pkg::ONE_Q) << 30) + DS / 2) / DS);
    localparam longint TP = longint'(((lci_pkg::ONE_E - ET) * longint'(lci_pkg::ONE_Q)
                                      + DT / 2) / DT);
    assign sig_tab[i]  = 16'((S < 0) ? longint'(lci_pkg::ONE_Q) - SP : SP);
    assign tanh_tab[i] = 16'((S < 0) ? -TP : TP);
  end

  logic signed [15:0] xc;
  logic [14:0]        u;
  logic [31:0]        scaled;
  logic [IDX_W-1:0]   idx_r;
  logic               sel_r;

  always_comb begin
    if (x < -16'sd16384) begin
      xc = -16'sd16384;
    end else if (x > 16'sd16383) begin
      xc = 16'sd16383;
    end else begin
      xc = x;
    end
    u      = 15'(xc + 16'sd16384);
    scaled = (32'(u) * DEPTH) >> 15;
  end

  always_ff @(posedge clk) begin
    idx_r <= IDX_W'(scaled);
    sel_r <= tanh_sel;
    val_r <= sel_r ? tanh_tab[idx_r] : sig_tab[idx_r];
  end

endmodule

### src/lstm_cell_inference_unit.sv
// Top level of the LSTM layer unit: sequencer, shared MAC, gate-sum ring and state chains.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid/in_stall, op, weight_*, feature_*, end_*  | in
//  result  | out_valid/out_stall, hidden_index/value, last      | out
//
// A feature is one pass of the
// single MAC that walks the gate-sum ring one cell per cycle behind the weight RAM read.
// End of step adds HIDDEN_UNITS+1 such ring passes (recurrent, bias), an activation
// lookup per gate and a state update per hidden unit.
// Reset clears the ring, cell and hidden states; the weight store is undefined until written.
// in_stall stays high while an item is in work or results are waiting; a stalled result holds.
module lstm_cell_inference_unit #(
  parameter int INPUT_FEATURES  = 10,
  parameter int HIDDEN_UNITS    = 8,
  parameter int ACT_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [9:0]         in_weight_addr,
  input  logic signed [15:0] in_weight_value,
  input  logic [3:0]         in_feature_index,
  input  logic signed [15:0] in_feature_value,
  input  logic               in_end_of_step,
  input  logic               in_end_of_window,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_hidden_index,
  output logic signed [15:0] out_hidden_value,
  output logic               out_last
);

  localparam int H           = HIDDEN_UNITS;
  localparam int G           = 4 * H;
  localparam int REC_BASE    = INPUT_FEATURES * G;
  localparam int BIAS_BASE   = (INPUT_FEATURES + H) * G;
  localparam int STORE_DEPTH = (INPUT_FEATURES + H + 1) * G;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int GW          = $clog2(G);
  localparam int CW          = $clog2(G + 1);
  localparam int HW          = (H > 1) ? $clog2(H) : 1;

  typedef enum logic [2:0] {
    IDLE, FEAT, REC, BIAS, ACT, UPD, OUTQ
  } state_t;

  state_t state_r;

  logic              in_xfer, out_xfer;
  logic [ADDR_W-1:0] base_r;
  logic [CW-1:0]     iss_cnt_r;
  logic [GW-1:0]     ret_cnt_r;
  logic [HW-1:0]     j_r, p_r;
  logic [1:0]        sub_r;
  logic [2:0]        u_r;
  logic              eos_r, eow_r;
  logic signed [15:0] x_r;
  logic              v1_r, v2_r;
  logic signed [31:0] prod_r, pi_r, pf_r, po_r;
  logic signed [15:0] og_r, nc_r;
  logic signed [15:0] h_q [H];
  logic signed [15:0] c_q [H];

  logic              pass_st, issuing, mac_retire, pass_done;
  logic              act_shift, act_last, upd_shift, upd_last;
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       rdata;
  logic signed [15:0] x_op;
  logic signed [32:0] prod_rnd;
  logic signed [21:0] rnd;
  logic signed [32:0] sum33;
  logic signed [31:0] mac_sum;
  logic signed [31:0] head_new;
  logic signed [31:0] ring_q [G];
  lci_pkg::cell_ctrl_t cell_ctrl;
  logic signed [15:0] act_x, act_val;
  logic              act_tanh;
  logic signed [33:0] nc_sum, nh_sum;
  logic signed [15:0] nh;

  assign in_stall  = (state_r != IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == OUTQ);
  assign out_xfer  = out_valid && !out_stall;
  assign out_hidden_index = 3'(p_r);
  assign out_hidden_value = h_q[0];
  assign out_last  = (32'(p_r) == H - 1);

  assign wr_en = in_xfer && (in_op == 1'(lci_pkg::OP_WEIGHT))
                 && (32'(in_weight_addr) < STORE_DEPTH);

  lci_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_wstore (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ADDR_W'(in_weight_addr)),
    .wdata (in_weight_value),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign pass_st    = (state_r == FEAT) || (state_r == REC) || (state_r == BIAS);
  assign issuing    = pass_st && (iss_cnt_r < CW'(G));
  assign rd_addr    = base_r + ADDR_W'(iss_cnt_r);
  assign mac_retire = pass_st && v2_r;
  assign pass_done  = mac_retire && (ret_cnt_r == GW'(G - 1));
  assign act_shift  = (state_r == ACT) && (sub_r == 2'd2);
  assign act_last   = act_shift && (ret_cnt_r == GW'(G - 1));
  assign upd_shift  = (state_r == UPD) && (u_r == 3'd5);
  assign upd_last   = upd_shift && (32'(p_r) == H - 1);

  always_comb begin
    case (state_r)
      FEAT:    x_op = x_r;
      REC:     x_op = h_q[0];
      default: x_op = 16'(lci_pkg::ONE_Q);
    endcase
  end

  // Round half up back to Q.11, then add into the head sum with 32-bit saturation.
  always_comb begin
    prod_rnd = 33'(prod_r) + 33'sd1024;
    rnd      = 22'(prod_rnd >>> 11);
    sum33    = 33'(ring_q[0]) + 33'(rnd);
    if (sum33[32] != sum33[31]) begin
      mac_sum = sum33[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      mac_sum = sum33[31:0];
    end
  end

  always_comb begin
    if (mac_retire) begin
      head_new = mac_sum;
    end else if (act_shift) begin
      head_new = 32'(act_val);
    end else begin
      head_new = ring_q[0];
    end
    cell_ctrl.shift = mac_retire || act_shift || upd_shift;
    cell_ctrl.clr   = upd_last;
  end

  for (genvar k = 0; k < G; k++) begin : g_ring
    lci_gate_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (cell_ctrl),
      .d     ((k == G - 1) ? head_new : ring_q[(k + 1) % G]),
      .q     (ring_q[k])
    );
  end

  always_comb begin
    if (state_r == UPD) begin
      act_x    = nc_r;
      act_tanh = 1'b1;
    end else begin
      act_x    = lci_pkg::sat16(34'(ring_q[0]));
      act_tanh = (32'(ret_cnt_r) >= 2 * H) && (32'(ret_cnt_r) < 3 * H);
    end
  end

  lci_act_lut #(.DEPTH(ACT_TABLE_DEPTH)) u_act (
    .clk      (clk),
    .x        (act_x),
    .tanh_sel (act_tanh),
    .val_r    (act_val)
  );

  assign nc_sum = (34'(pi_r) + 34'(pf_r) + 34'sd1024) >>> 11;
  assign nh_sum = (34'(po_r) + 34'sd1024) >>> 11;
  assign nh     = lci_pkg::sat16(nh_sum);

  // MAC datapath and update products.
  always_ff @(posedge clk) begin
    prod_r <= $signed(rdata) * x_op;
    if (u_r == 3'd0) begin
      pi_r <= $signed(ring_q[0][15:0]) * $signed(ring_q[2 * H][15:0]);
      pf_r <= $signed(ring_q[H][15:0]) * c_q[0];
      og_r <= ring_q[3 * H][15:0];
    end
    if (u_r == 3'd1) begin
      nc_r <= lci_pkg::sat16(nc_sum);
    end
    if (u_r == 3'd4) begin
      po_r <= og_r * act_val;
    end
  end

  // Cell and hidden state chains; the head of each is the unit being worked on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < H; i++) begin
        h_q[i] <= '0;
        c_q[i] <= '0;
      end
    end else begin
      if (pass_done && (state_r == REC)) begin
        for (int i = 0; i < H - 1; i++) h_q[i] <= h_q[i + 1];
        h_q[H - 1] <= h_q[0];
      end else if (upd_shift) begin
        for (int i = 0; i < H - 1; i++) begin
          h_q[i] <= h_q[i + 1];
          c_q[i] <= c_q[i + 1];
        end
        h_q[H - 1] <= nh;
        c_q[H - 1] <= nc_r;
      end else if (out_xfer) begin
        for (int i = 0; i < H - 1; i++) h_q[i] <= h_q[i + 1];
        h_q[H - 1] <= '0;
      end
      if (upd_last && eow_r) begin
        for (int i = 0; i < H; i++) c_q[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= IDLE;
      iss_cnt_r <= '0;
      ret_cnt_r <= '0;
      j_r       <= '0;
      p_r       <= '0;
      sub_r     <= '0;
      u_r       <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      eos_r     <= 1'b0;
      eow_r     <= 1'b0;
    end else begin
      v1_r <= issuing;
      v2_r <= v1_r;
      if (issuing) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
      end
      if (mac_retire) begin
        ret_cnt_r <= ret_cnt_r + 1'b1;
      end
      case (state_r)
        IDLE: begin
          if (in_xfer && (in_op == 1'(lci_pkg::OP_FEATURE))) begin
            x_r       <= in_feature_value;
            eos_r     <= in_end_of_step;
            eow_r     <= in_end_of_window;
            iss_cnt_r <= '0;
            ret_cnt_r <= '0;
            if (32'(in_feature_index) < INPUT_FEATURES) begin
              base_r  <= ADDR_W'(32'(in_feature_index) * G);
              state_r <= FEAT;
            end else if (in_end_of_step || in_end_of_window) begin
              base_r  <= ADDR_W'(REC_BASE);
              j_r     <= '0;
              state_r <= REC;
            end
          end
        end
        FEAT: begin
          if (pass_done) begin
            iss_cnt_r <= '0;
            ret_cnt_r <= '0;
            if (eos_r || eow_r) begin
              base_r  <= ADDR_W'(REC_BASE);
              j_r     <= '0;
              state_r <= REC;
            end else begin
              state_r <= IDLE;
            end
          end
        end
        REC: begin
          if (pass_done) begin
            iss_cnt_r <= '0;
            ret_cnt_r <= '0;
            if (32'(j_r) == H - 1) begin
              base_r  <= ADDR_W'(BIAS_BASE);
              state_r <= BIAS;
            end else begin
              base_r  <= base_r + ADDR_W'(G);
              j_r     <= j_r + 1'b1;
            end
          end
        end
        BIAS: begin
          if (pass_done) begin
            ret_cnt_r <= '0;
            sub_r     <= '0;
            state_r   <= ACT;
          end
        end
        ACT: begin
          sub_r <= (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
          if (act_shift) begin
            ret_cnt_r <= ret_cnt_r + 1'b1;
          end
          if (act_last) begin
            u_r     <= '0;
            p_r     <= '0;
            state_r <= UPD;
          end
        end
        UPD: begin
          u_r <= (u_r == 3'd5) ? 3'd0 : u_r + 3'd1;
          if (upd_shift) begin
            p_r <= p_r + 1'b1;
          end
          if (upd_last) begin
            p_r     <= '0;
            state_r <= eow_r ? OUTQ : IDLE;
          end
        end
        OUTQ: begin
          if (out_xfer) begin
            p_r <= p_r + 1'b1;
            if (out_last) begin
              p_r     <= '0;
              state_r <= IDLE;
            end
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    mac_retire |-> (CW'(ret_cnt_r) < iss_cnt_r))
    else $error("ring retired a product that was never issued");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (c_q[0] == 16'sd0))
    else $error("cell state not cleared while window results are out");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last) |=> !out_valid)
    else $error("results continue after the final hidden value");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ACT || state_r == UPD) |-> !v1_r && !v2_r)
    else $error("MAC pipeline still busy after the bias pass");

endmodule
